// ----- hw/rtl/bua_pkg.sv -----
// bua_pkg: shared constants, payload types and state codes of the bitmap unit allocator
`default_nettype none

package bua_pkg;

  // memory geometry
  localparam int MEM_UNITS   = 1024;
  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = MEM_UNITS / WORD_W;
  localparam int ADDR_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CADDR_W     = ADDR_W + 1;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = WORD_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int CHUNK_BIT_W = $clog2(CHUNK_W);
  localparam int WCNT_W      = $clog2(WORD_W + 1);
  localparam int CNT_W       = $clog2(MEM_UNITS + 1);

  // field widths
  localparam int START_W     = 10;
  localparam int SIZE_W      = 11;
  localparam int IDX_FIELD_W = 10;
  localparam int RESERVE_W   = 11;
  localparam int CMP_W       = (CNT_W > SIZE_W + 1) ? CNT_W : SIZE_W + 1;

  localparam logic [RESERVE_W-1:0] RESERVE_RESET = RESERVE_W'(64);

  // register port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_RESERVE = '0;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_END = 2'd2
  } status_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [START_W-1:0] start_req;
    logic [SIZE_W-1:0]  size;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_FIELD_W-1:0] first_index;
    logic [SIZE_W-1:0]      units_done;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_DECIDE,
    S_RD,
    S_EVAL,
    S_APPLY,
    S_PART,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bua_ram.sv -----
// bua_ram: generic single write port, single read port ram with registered read
`default_nettype none

module bua_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_unit_allocator.sv -----
// bitmap_unit_allocator: top level of the bitmap unit allocator
//
// The occupancy bitmap (one bit per memory unit, 1 = used) lives in a ram of
// NUM_WORDS words of WORD_W bits; a per-word valid flag cleared at reset makes
// every word read as all free until first written, so there is no clearing pass.
// Requests are handled one at a time. An allocate transfer first streams the
// whole bitmap through the read port, one word a cycle, to count free units and
// locate the lowest free unit, then decides against the reserve. A free transfer
// skips the count. The marking or clearing pass then visits words from the lowest
// free word (allocate) or the start word (free), reading, evaluating and writing
// back each word in turn; the one word in which the request runs out is finished
// eight bits a cycle. A free of zero size visits no words. The next request is
// taken as soon as the result register is loaded, even while that result still
// waits for its transfer on the output side; its own result then waits until that
// transfer has gone. The reserve register sits at address 0.
`default_nettype none

module bitmap_unit_allocator
  import bua_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  function automatic logic [WCNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
    logic [WCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + WCNT_W'(w[i]);
    end
    return n;
  endfunction

  // lowest set bit, found as first nonzero byte then first bit in it
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
    logic [CHUNK_IDX_W-1:0] ck;
    logic [CHUNK_W-1:0]     cw;
    logic [CHUNK_BIT_W-1:0] b;
    ck = '0;
    b  = '0;
    for (int k = NUM_CHUNKS - 1; k >= 0; k--) begin
      if (w[k*CHUNK_W +: CHUNK_W] != '0) begin
        ck = CHUNK_IDX_W'(k);
      end
    end
    cw = w[ck*CHUNK_W +: CHUNK_W];
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (cw[j]) begin
        b = CHUNK_BIT_W'(j);
      end
    end
    return {ck, b};
  endfunction

  state_t state, state_next;

  // configuration
  logic [RESERVE_W-1:0] reserve;

  // request being worked on
  in_item_t             req;
  logic [SIZE_W-1:0]    remaining;
  logic [SIZE_W-1:0]    done;
  status_t              status_q;
  logic [IDX_FIELD_W-1:0] first_q;
  logic [ADDR_W-1:0]    waddr;
  logic                 first_word;

  // count pass
  logic [CADDR_W-1:0]   cnt_addr;
  logic                 pend;
  logic [ADDR_W-1:0]    pend_addr;
  logic [CNT_W-1:0]     free_count;
  logic                 found;
  logic [ADDR_W-1:0]    low_word;
  logic [WORD_W-1:0]    low_zeros;

  // word being modified
  logic [WORD_W-1:0]    word_q;
  logic [WORD_W-1:0]    cand_q;
  logic [WCNT_W-1:0]    cnt_q;
  logic [CHUNK_IDX_W-1:0] chunk;

  // bitmap storage
  logic [NUM_WORDS-1:0] row_valid;
  logic                 rd_valid;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  // combinational helpers
  logic [WORD_W-1:0]    eff_word;
  logic [WORD_W-1:0]    zeros;
  logic [WORD_W-1:0]    start_mask;
  logic [WORD_W-1:0]    cand;
  logic [CMP_W-1:0]     need_total;
  logic                 oom;
  logic                 apply_fits;
  logic [SIZE_W-1:0]    apply_rem;
  logic [SIZE_W-1:0]    apply_done;
  logic                 apply_end;
  logic                 last_word;
  logic [WORD_W-1:0]    part_word;
  logic [SIZE_W-1:0]    part_rem;
  logic [SIZE_W-1:0]    part_done;
  logic                 part_end;
  logic                 in_take;
  logic                 in_short;
  logic                 out_free;
  logic                 cfg_wr;

  bua_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == REG_RESERVE);

  always_comb begin
    case (paddr)
      REG_RESERVE: prdata = PDATA_W'(reserve);
      default:     prdata = '0;
    endcase
  end

  // free request that touches nothing: zero size or start beyond the map
  assign in_short = (in_data.req_type == REQ_FREE) &&
                    ((in_data.size == '0) || (32'(in_data.start_req) >= 32'(MEM_UNITS)));

  // a word never written reads as all free
  assign eff_word   = rd_valid ? ram_rdata : '0;
  assign zeros      = ~eff_word;
  assign start_mask = {WORD_W{1'b1}} << req.start_req[BIT_W-1:0];
  assign cand       = (req.req_type == REQ_FREE) ?
                      (eff_word & (first_word ? start_mask : {WORD_W{1'b1}})) : zeros;

  assign need_total = CMP_W'(req.size) + CMP_W'(reserve);
  assign oom        = CMP_W'(free_count) < need_total;

  assign last_word  = (waddr == ADDR_W'(NUM_WORDS - 1));
  assign apply_fits = SIZE_W'(cnt_q) <= remaining;
  assign apply_rem  = remaining - SIZE_W'(cnt_q);
  assign apply_done = done + SIZE_W'(cnt_q);
  assign apply_end  = (apply_rem == '0) || last_word;

  // flip candidates of one byte while units are still owed
  always_comb begin
    part_word = word_q;
    part_rem  = remaining;
    part_done = done;
    for (int j = 0; j < CHUNK_W; j++) begin
      if (cand_q[{chunk, CHUNK_BIT_W'(j)}] && (part_rem != '0)) begin
        part_word[{chunk, CHUNK_BIT_W'(j)}] = ~part_word[{chunk, CHUNK_BIT_W'(j)}];
        part_rem  = part_rem - 1'b1;
        part_done = part_done + 1'b1;
      end
    end
  end

  assign part_end = (part_rem == '0) || (chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = word_q ^ cand_q;
    ram_raddr  = (state == S_COUNT) ? cnt_addr[ADDR_W-1:0] : waddr;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.req_type == REQ_ALLOC) begin
            state_next = S_COUNT;
          end else if (in_short) begin
            state_next = S_OUT;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_COUNT: begin
        if ((cnt_addr == CADDR_W'(NUM_WORDS)) && !pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (oom || (req.size == '0) || !found) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD:   state_next = S_EVAL;
      S_EVAL: state_next = S_APPLY;
      S_APPLY: begin
        if (apply_fits) begin
          ram_we     = 1'b1;
          state_next = apply_end ? S_OUT : S_RD;
        end else begin
          state_next = S_PART;
        end
      end
      S_PART: begin
        ram_wdata = part_word;
        if (part_end) begin
          ram_we     = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // valid flags, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      reserve   <= RESERVE_RESET;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (ram_we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cfg_wr) begin
        reserve <= pwdata[RESERVE_W-1:0];
      end
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_COUNT) begin
        pend <= (cnt_addr < CADDR_W'(NUM_WORDS));
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= row_valid[ram_raddr];
    if ((state == S_OUT) && out_free) begin
      out_data.status      <= status_q;
      out_data.first_index <= first_q;
      out_data.units_done  <= done;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          req        <= in_data;
          done       <= '0;
          remaining  <= in_data.size;
          first_q    <= '0;
          first_word <= 1'b1;
          waddr      <= ADDR_W'(in_data.start_req >> BIT_W);
          cnt_addr   <= '0;
          free_count <= '0;
          found      <= 1'b0;
          status_q   <= (in_short && (in_data.size != '0)) ? ST_END : ST_OK;
        end
      end
      S_COUNT: begin
        if (cnt_addr < CADDR_W'(NUM_WORDS)) begin
          cnt_addr  <= cnt_addr + 1'b1;
          pend_addr <= cnt_addr[ADDR_W-1:0];
        end
        if (pend) begin
          free_count <= free_count + CNT_W'(popcount(zeros));
          if (!found && (zeros != '0)) begin
            found     <= 1'b1;
            low_word  <= pend_addr;
            low_zeros <= zeros;
          end
        end
      end
      S_DECIDE: begin
        if (oom) begin
          status_q <= ST_OOM;
        end else if (found) begin
          first_q <= IDX_FIELD_W'({low_word, first_set(low_zeros)});
          waddr   <= low_word;
        end
      end
      S_EVAL: begin
        word_q <= eff_word;
        cand_q <= cand;
        cnt_q  <= popcount(cand);
      end
      S_APPLY: begin
        chunk <= '0;
        if (apply_fits) begin
          remaining <= apply_rem;
          done      <= apply_done;
          if (!apply_end) begin
            waddr      <= waddr + 1'b1;
            first_word <= 1'b0;
          end
          // free ran out of memory with units still owed
          if (apply_end && (apply_rem != '0) && (req.req_type == REQ_FREE)) begin
            status_q <= ST_END;
          end
        end
      end
      S_PART: begin
        word_q    <= part_word;
        remaining <= part_rem;
        done      <= part_done;
        chunk     <= chunk + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // a failed allocation reports no units and no index
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_OOM)) |->
      ((out_data.units_done == '0) && (out_data.first_index == '0)))
    else $error("failed allocation reports units");

  // never more units handled than requested
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (done <= req.size))
    else $error("units done exceeds request size");

  // a successful free clears exactly the requested count
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && (req.req_type == REQ_FREE) && (status_q == ST_OK)) |->
      (done == req.size))
    else $error("free reported ok with units missing");

  // partial word handling only starts with units still owed
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PART) |-> (remaining != '0))
    else $error("partial word entered with nothing owed");

endmodule

`default_nettype wire

// ----- tb/bitmap_unit_allocator_tb.sv -----
// bitmap_unit_allocator_tb: self-checking testbench of the bitmap unit allocator
module bitmap_unit_allocator_tb;
  import bua_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 4000;
  // length of the one long receiver hold-off, and when it starts
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;
  // cycles left after the last result to catch anything spurious
  localparam int TAIL_CYCLES = 120;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // requests waiting for the driver, and results predicted but not yet seen
  in_item_t  pending_requests[$];
  out_item_t predicted_results[$];

  // predictor copy of the bitmap (1 = unit used) and of the reserve register
  logic [MEM_UNITS-1:0] unit_used = '0;
  logic [RESERVE_W-1:0] reserve_setting = RESERVE_RESET;

  // chance in a hundred that either side idles in a given cycle
  int idle_pct = 17;

  logic in_taken = 1'b0;
  int   requests_queued = 0;
  int   requests_taken = 0;
  int   results_checked = 0;
  int   error_count = 0;
  int   quiet_cycles = 0;
  int   rx_hold_left = 0;
  bit   rx_hold_done = 1'b0;
  int   setting_count = 1;
  int   alloc_ok = 0;
  int   alloc_oom = 0;
  int   free_ok = 0;
  int   free_short = 0;

  bitmap_unit_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // works out the result of one request and updates the predicted bitmap
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    int        free_cnt;
    int        lowest;
    int        done;
    res = '0;
    free_cnt = 0;
    lowest = MEM_UNITS;
    done = 0;
    if (req.req_type == REQ_ALLOC) begin
      // count free units and note the lowest one
      for (int u = 0; u < MEM_UNITS; u++) begin
        if (!unit_used[u]) begin
          if (lowest == MEM_UNITS) lowest = u;
          free_cnt++;
        end
      end
      if (free_cnt < int'(req.size) + int'(reserve_setting)) begin
        res.status = ST_OOM;
      end else begin
        res.status = ST_OK;
        // a passing allocation with no free unit at all reports index 0
        if (lowest < MEM_UNITS) begin
          res.first_index = IDX_FIELD_W'(lowest);
          for (int u = lowest; u < MEM_UNITS && done < int'(req.size); u++) begin
            if (!unit_used[u]) begin
              unit_used[u] = 1'b1;
              done++;
            end
          end
        end
      end
    end else begin
      // clear occupied units from the start index, stopping at the end of memory
      for (int u = int'(req.start_req); u < MEM_UNITS && done < int'(req.size); u++) begin
        if (unit_used[u]) begin
          unit_used[u] = 1'b0;
          done++;
        end
      end
      res.status = (done < int'(req.size)) ? ST_END : ST_OK;
    end
    res.units_done = SIZE_W'(done);
    return res;
  endfunction

  // tallies only: whether an allocation will pass the reserve test
  function automatic bit serve_peek_ok(in_item_t req);
    int free_cnt;
    free_cnt = 0;
    for (int u = 0; u < MEM_UNITS; u++) if (!unit_used[u]) free_cnt++;
    return free_cnt >= int'(req.size) + int'(reserve_setting);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic in_item_t request(req_kind_t kind, int start, int units);
    in_item_t r;
    r.req_type = kind;
    r.start_req = START_W'(start);
    r.size = SIZE_W'(units);
    return r;
  endfunction

  // mostly small sizes, now and then large ones and the whole memory
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(0, 32);
    else if (roll < 88) return $urandom_range(33, 200);
    else if (roll < 97) return $urandom_range(201, 1023);
    else return MEM_UNITS;
  endfunction

  // frees lean towards the low end of memory, where allocations pack
  function automatic in_item_t random_request();
    in_item_t r;
    r.req_type = ($urandom_range(99) < 55) ? REQ_ALLOC : REQ_FREE;
    r.start_req = $urandom_range(1) ? START_W'($urandom_range(0, 255))
                                    : START_W'($urandom_range(0, 1023));
    r.size = SIZE_W'(pick_size());
    return r;
  endfunction

  task automatic add_request(in_item_t r);
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic add_random(int count);
    for (int n = 0; n < count; n++) add_request(random_request());
  endtask

  // sender pause: wait until every queued request has had its result checked
  task automatic wait_idle();
    @(negedge clk);
    while (requests_taken != requests_queued || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle held until pready
  task automatic write_reserve(int value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_RESERVE;
    pwdata = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    reserve_setting = RESERVE_W'(value);
    setting_count++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // request driver: a new transfer is offered only once the last one went through
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off once results are flowing
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_hold_done && results_checked >= HOLD_AFTER) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: check the result transfer first, then predict for the request transfer,
  // so a result never meets an expectation pushed at the same edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request outstanding", out_data.units_done, 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.first_index != want.first_index)
            report_mismatch("first_index", out_data.first_index, want.first_index);
          if (out_data.units_done != want.units_done)
            report_mismatch("units_done", out_data.units_done, want.units_done);
          case (want.status)
            ST_OOM:  alloc_oom++;
            ST_END:  free_short++;
            default: ;
          endcase
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_ALLOC && serve_peek_ok(in_data)) alloc_ok++;
        else if (in_data.req_type == REQ_FREE) free_ok++;
        predicted_results.push_back(serve_request(in_data));
        requests_taken++;
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
    end
  end

  // watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset reserve of 64: fill to the reserve edge, punch a hole, refill it
    add_request(request(REQ_ALLOC, 10'h3FF, 0));
    add_request(request(REQ_FREE, 0, 0));
    add_request(request(REQ_ALLOC, 0, 961));
    add_request(request(REQ_ALLOC, 0, 960));
    add_request(request(REQ_ALLOC, 0, 1));
    add_request(request(REQ_FREE, 100, 50));
    add_request(request(REQ_ALLOC, 0, 10));
    add_request(request(REQ_FREE, 1023, 5));
    add_request(request(REQ_FREE, 10'h2AA, 3));
    add_request(request(REQ_FREE, 0, MEM_UNITS));
    wait_idle();

    // no reserve: take the whole memory, then allocate with nothing free
    write_reserve(0);
    add_request(request(REQ_ALLOC, 10'h155, MEM_UNITS));
    add_request(request(REQ_ALLOC, 0, 0));
    add_request(request(REQ_ALLOC, 0, 1));
    add_request(request(REQ_FREE, 1023, 1));
    add_request(request(REQ_FREE, 512, MEM_UNITS));
    add_request(request(REQ_ALLOC, 0, 513));
    add_request(request(REQ_ALLOC, 0, 512));
    add_request(request(REQ_FREE, 0, MEM_UNITS));
    wait_idle();

    // reserve equal to the whole memory: only empty allocations pass
    write_reserve(MEM_UNITS);
    add_request(request(REQ_ALLOC, 0, 0));
    add_request(request(REQ_ALLOC, 0, 1));
    add_request(request(REQ_FREE, 0, 1));
    add_random(50);
    wait_idle();

    write_reserve(1023);
    add_random(50);
    wait_idle();

    // a stretch with no random idling on either side
    write_reserve($urandom_range(0, 255));
    idle_pct = 0;
    add_random(250);
    wait_idle();
    idle_pct = 17;

    write_reserve(0);
    add_random(250);
    wait_idle();

    write_reserve($urandom_range(0, MEM_UNITS));
    add_random(250);
    wait_idle();

    write_reserve(64);
    add_random(275);
    wait_idle();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", 0, predicted_results.size());

    $display("covered %0d requests under %0d reserve settings, %0d results checked",
             requests_taken, setting_count, results_checked);
    $display("allocations passed %0d, out of memory %0d; frees %0d, %0d ran off the end",
             alloc_ok, alloc_oom, free_ok, free_short);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bua_pkg.sv
hw/rtl/bua_ram.sv
hw/rtl/bitmap_unit_allocator.sv
tb/bitmap_unit_allocator_tb.sv
